// ----- sv/mrle_pkg.sv -----
package mrle_pkg;

    // Size limit on the decoded output of one stream.
    localparam int unsigned OUTPUT_LIMIT = 49152;

    // Depth of the run queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Token decoding constants.
    localparam logic [7:0] TOKEN_IMPLICIT = 8'h80;
    localparam logic [6:0] TOKEN_LEN_MASK = 7'h7f;
    localparam logic [8:0] FULL_RUN_LEN   = 9'd256;

    // Configuration register indexes.
    typedef enum logic [7:0] {
        REG_MARKER_VALUE     = 8'd0,
        REG_LENGTH_THRESHOLD = 8'd1,
        REG_FIRST_FILL_BYTE  = 8'd2,
        REG_SECOND_FILL_BYTE = 8'd3
    } cfg_reg_t;

    // One packed byte as it enters the block.
    typedef struct packed {
        logic [7:0] packed_byte;
        logic       end_of_stream;
    } in_item_t;

    // One run descriptor as it leaves the block.
    typedef struct packed {
        logic [7:0] run_value;
        logic [8:0] run_length;
        logic       limit_reached;
        logic       last_run;
    } out_item_t;

    // A decoded run before the size limit is applied.
    typedef struct packed {
        logic [7:0] value;
        logic [8:0] length;
        logic       last;
    } run_t;

    // Status of the run queue.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- sv/mrle_front.sv -----
module mrle_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  logic              byte_accept,
    input  mrle_pkg::in_item_t byte_item,
    input  logic              cfg_valid,
    input  logic [7:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    output logic              push,
    output mrle_pkg::run_t    push_run
);
    import mrle_pkg::*;

    typedef enum logic [1:0] {
        PH_PLAIN  = 2'd0,
        PH_TOKEN  = 2'd1,
        PH_FILLER = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [8:0] pending_reg, pending_next;
    logic [7:0] marker_reg, threshold_reg, fill1_reg, fill2_reg;

    logic       has_run;
    logic [7:0] b;
    logic       last;
    logic [6:0] tok_len;

    assign b       = byte_item.packed_byte;
    assign last    = byte_item.end_of_stream;
    assign tok_len = b[6:0] & TOKEN_LEN_MASK;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg    <= '0;
            threshold_reg <= '0;
            fill1_reg     <= '0;
            fill2_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MARKER_VALUE:     marker_reg    <= cfg_data;
                REG_LENGTH_THRESHOLD: threshold_reg <= cfg_data;
                REG_FIRST_FILL_BYTE:  fill1_reg     <= cfg_data;
                REG_SECOND_FILL_BYTE: fill2_reg     <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Classify the byte against the current phase.
    always_comb
    begin
        has_run      = 1'b0;
        push_run     = '0;
        phase_next   = phase_reg;
        pending_next = pending_reg;
        unique case (phase_reg)
            PH_TOKEN:
            begin
                phase_next = PH_PLAIN;
                if ((b & TOKEN_IMPLICIT) != 8'd0)
                begin
                    has_run = 1'b1;
                    if (tok_len != 7'd0)
                    begin
                        push_run.value  = ({1'b0, tok_len} < threshold_reg) ? fill1_reg
                                                                            : fill2_reg;
                        push_run.length = {2'b00, tok_len};
                    end
                    else
                    begin
                        push_run.value  = 8'd0;
                        push_run.length = FULL_RUN_LEN;
                    end
                end
                else
                begin
                    pending_next = (b != 8'd0) ? {1'b0, b} : FULL_RUN_LEN;
                    if (last)
                    begin
                        // Stream ends before the filler: the filler reads as zero.
                        has_run         = 1'b1;
                        push_run.value  = 8'd0;
                        push_run.length = pending_next;
                    end
                    else
                    begin
                        phase_next = PH_FILLER;
                    end
                end
            end
            PH_FILLER:
            begin
                phase_next      = PH_PLAIN;
                has_run         = 1'b1;
                push_run.value  = b;
                push_run.length = pending_reg;
            end
            default:
            begin
                // Plain byte or marker; the unused code behaves the same.
                phase_next = PH_PLAIN;
                if (b != marker_reg)
                begin
                    has_run         = 1'b1;
                    push_run.value  = b;
                    push_run.length = 9'd1;
                end
                else if (last)
                begin
                    // A trailing marker reads its token as zero: 256 zeros.
                    has_run         = 1'b1;
                    push_run.value  = 8'd0;
                    push_run.length = FULL_RUN_LEN;
                end
                else
                begin
                    phase_next = PH_TOKEN;
                end
            end
        endcase
        push_run.last = last;
    end

    assign push = byte_accept && has_run;

    // Phase machine; the end of a stream returns it to its reset state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_PLAIN;
            pending_reg <= '0;
        end
        else if (byte_accept)
        begin
            phase_reg   <= last ? PH_PLAIN : phase_next;
            pending_reg <= last ? 9'd0 : pending_next;
        end
    end

    // Every accepted last byte produces a run for the back to see.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_accept && last |-> push)
        else $error("last byte produced no run");

    assert property (@(posedge clk) disable iff (!rst_n)
        byte_accept && last |=> phase_reg == PH_PLAIN && pending_reg == 9'd0)
        else $error("phase not cleared at end of stream");

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_run.length != 9'd0)
        else $error("zero-length run pushed");

    // byte_valid is only qualified through byte_accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_accept |-> byte_valid)
        else $error("byte accepted without valid");

endmodule

// ----- sv/mrle_queue.sv -----
module mrle_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  mrle_pkg::run_t         push_run,
    input  logic                   pop,
    output mrle_pkg::run_t         head_run,
    output mrle_pkg::queue_status_t status
);
    import mrle_pkg::*;

    run_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;

    assign status.full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_run     = mem[rd_ptr_reg];

    // Payload storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_run;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= QUEUE_AW'((QUEUE_CW'(wr_ptr_reg) + 1'b1) % QUEUE_DEPTH);
            end
            if (pop)
            begin
                rd_ptr_reg <= QUEUE_AW'((QUEUE_CW'(rd_ptr_reg) + 1'b1) % QUEUE_DEPTH);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("pop from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ----- sv/mrle_back.sv -----
module mrle_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mrle_pkg::run_t          head_run,
    input  mrle_pkg::queue_status_t status,
    output logic                    pop,
    output logic                    run_valid,
    input  logic                    run_stall,
    output mrle_pkg::out_item_t     run_item
);
    import mrle_pkg::*;

    logic [15:0] total_reg, total_next;
    logic        dropping_reg, dropping_next;
    logic        valid_reg;
    out_item_t   item_reg;

    // Take the head run whenever the output register is free or being taken.
    assign pop = !status.empty && (!valid_reg || !run_stall);

    // Running total and limit check.
    always_comb
    begin
        total_next    = total_reg + {7'd0, head_run.length};
        dropping_next = (total_next >= 16'(OUTPUT_LIMIT));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= '0;
            dropping_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                valid_reg <= !dropping_reg;
                if (head_run.last)
                begin
                    total_reg    <= '0;
                    dropping_reg <= 1'b0;
                end
                else if (!dropping_reg)
                begin
                    total_reg    <= total_next;
                    dropping_reg <= dropping_next;
                end
            end
            else if (!run_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (pop && !dropping_reg)
        begin
            item_reg.run_value     <= head_run.value;
            item_reg.run_length    <= head_run.length;
            item_reg.limit_reached <= dropping_next;
            item_reg.last_run      <= head_run.last;
        end
    end

    assign run_valid = valid_reg;
    assign run_item  = item_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        pop && head_run.last |=> total_reg == 16'd0 && !dropping_reg)
        else $error("stream state not cleared after last run");

    assert property (@(posedge clk) disable iff (!rst_n)
        dropping_reg |-> total_reg >= 16'(OUTPUT_LIMIT))
        else $error("dropping without reaching the limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop && !dropping_reg |=> valid_reg)
        else $error("kept run not presented");

endmodule

// ----- sv/marker_rle_run_decoder_unit.sv -----
// A run is queued as its last byte is accepted, then registered. Throughput: one
// packed byte per cycle unless the queue is full, set by the front phase register
// and the back's total add and limit compare; a four-item queue decouples the two.
// Reset (rst_n, asynchronous, active low) clears the phase, pending length, total,
// drop flag, queue and output valid, and sets all configuration registers to zero.
module marker_rle_run_decoder_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  mrle_pkg::in_item_t  byte_item,
    output logic                run_valid,
    input  logic                run_stall,
    output mrle_pkg::out_item_t run_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import mrle_pkg::*;

    logic          byte_accept;
    logic          push;
    logic          pop;
    run_t          push_run;
    run_t          head_run;
    queue_status_t status;

    assign cfg_ready   = 1'b1;
    assign byte_stall  = status.full;
    assign byte_accept = byte_valid && !byte_stall;

    mrle_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_accept (byte_accept),
        .byte_item   (byte_item),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .push_run    (push_run)
    );

    mrle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (push_run),
        .pop      (pop),
        .head_run (head_run),
        .status   (status)
    );

    mrle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_run  (head_run),
        .status    (status),
        .pop       (pop),
        .run_valid (run_valid),
        .run_stall (run_stall),
        .run_item  (run_item)
    );

endmodule

// ----- verif/tb_marker_rle_run_decoder_unit.sv -----
module tb_marker_rle_run_decoder_unit;

    import mrle_pkg::*;

    localparam int unsigned BYTE_TARGET  = 920;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned IDLE_PCT     = 18;

    // Decoder phases of the predictor.
    typedef enum logic [1:0] {
        PH_PLAIN  = 2'd0,
        PH_TOKEN  = 2'd1,
        PH_FILLER = 2'd2
    } dec_phase_t;

    // Rows of the directed table.
    typedef enum logic {
        ROW_BYTE,
        ROW_REG
    } row_kind_t;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_RUN
    } row_check_t;

    typedef struct {
        row_kind_t  kind;
        logic [7:0] a;
        logic [7:0] b;
        row_check_t chk;
        out_item_t  run;
    } plan_row_t;

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    in_item_t  byte_item;
    logic      run_valid;
    logic      run_stall;
    out_item_t run_item;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [7:0] cfg_index;
    logic [7:0] cfg_data;

    // Predictor copy of the registers and the decode state.
    logic [7:0]  reg_marker;
    logic [7:0]  reg_threshold;
    logic [7:0]  reg_fill_short;
    logic [7:0]  reg_fill_long;
    dec_phase_t  dec_phase;
    logic [8:0]  dec_pending;
    logic [15:0] dec_total;
    bit          dec_dropping;

    out_item_t   expected_runs[$];
    plan_row_t   plan[$];
    out_item_t   next_run;

    int unsigned cycles;
    int unsigned mismatches;
    int unsigned bytes_decoded;
    int unsigned streams_done;
    int unsigned runs_checked;
    int unsigned limit_runs;
    int unsigned reg_writes;
    bit          calm;
    bit          held;
    bit          flooded;

    marker_rle_run_decoder_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .run_valid  (run_valid),
        .run_stall  (run_stall),
        .run_item   (run_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Adds a run to the stream total and flags the size limit.
    function automatic bit add_run(input logic [7:0] value, input logic [8:0] len,
                                   input bit last, output out_item_t run);
        dec_total = dec_total + 16'(len);
        if (dec_total >= OUTPUT_LIMIT)
            dec_dropping = 1'b1;
        run.run_value     = value;
        run.run_length    = len;
        run.limit_reached = dec_dropping;
        run.last_run      = last;
        return 1'b1;
    endfunction

    // Turns a token byte into a run, or arms the filler phase.
    function automatic bit decode_token(input logic [7:0] tok, input bit last,
                                        output out_item_t run);
        logic [6:0] len7;
        len7 = tok[6:0];
        run  = '0;
        if (tok[7])
        begin
            if (len7 != 7'd0)
                return add_run((8'(len7) < reg_threshold) ? reg_fill_short : reg_fill_long,
                               9'(len7), last, run);
            return add_run(8'h00, FULL_RUN_LEN, last, run);
        end
        dec_pending = (tok != 8'h00) ? 9'(tok) : FULL_RUN_LEN;
        if (last)
            return add_run(8'h00, dec_pending, 1'b1, run);
        dec_phase = PH_FILLER;
        return 1'b0;
    endfunction

    // Advances the predicted decoder by one packed byte.
    function automatic bit decode_byte(input in_item_t item, output out_item_t run);
        bit got;
        got = 1'b0;
        run = '0;
        if (!dec_dropping)
        begin
            case (dec_phase)
                PH_TOKEN:
                begin
                    dec_phase = PH_PLAIN;
                    got = decode_token(item.packed_byte, item.end_of_stream, run);
                end
                PH_FILLER:
                begin
                    dec_phase = PH_PLAIN;
                    got = add_run(item.packed_byte, dec_pending, item.end_of_stream, run);
                end
                default:
                begin
                    dec_phase = PH_PLAIN;
                    if (item.packed_byte != reg_marker)
                        got = add_run(item.packed_byte, 9'd1, item.end_of_stream, run);
                    else if (item.end_of_stream)
                        got = decode_token(8'h00, 1'b1, run);
                    else
                        dec_phase = PH_TOKEN;
                end
            endcase
        end
        if (item.end_of_stream)
        begin
            dec_phase    = PH_PLAIN;
            dec_pending  = '0;
            dec_total    = '0;
            dec_dropping = 1'b0;
        end
        return got;
    endfunction

    function automatic void put_byte(input logic [7:0] b, input bit eos, input row_check_t chk,
                                     input logic [7:0] v, input logic [8:0] len, input bit last);
        plan_row_t row;
        row.kind = ROW_BYTE;
        row.a    = b;
        row.b    = 8'(eos);
        row.chk  = chk;
        row.run  = '{run_value: v, run_length: len, limit_reached: 1'b0, last_run: last};
        plan.push_back(row);
    endfunction

    function automatic void put_reg(input logic [7:0] idx, input logic [7:0] data);
        plan_row_t row;
        row.kind = ROW_REG;
        row.a    = idx;
        row.b    = data;
        row.chk  = CHK_NONE;
        row.run  = '0;
        plan.push_back(row);
    endfunction

    task automatic report(input string what, input int unsigned want, input int unsigned got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endtask

    // Holds the sender off until every expected run is out and the pipeline is quiet.
    task automatic wait_idle();
        while (expected_runs.size() != 0)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    // Writes one configuration register once the block is idle.
    task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
        wait_idle();
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_MARKER_VALUE:     reg_marker     = data;
            REG_LENGTH_THRESHOLD: reg_threshold  = data;
            REG_FIRST_FILL_BYTE:  reg_fill_short = data;
            REG_SECOND_FILL_BYTE: reg_fill_long  = data;
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Presents one item, with random idle cycles ahead of it, and predicts its run.
    task automatic send_byte(input in_item_t item, input row_check_t chk,
                             input out_item_t typed);
        out_item_t pred;
        bit        got;
        bit        was_dropping;
        calm = (bytes_decoded >= 450) && (bytes_decoded < 650);
        while (!calm && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_item  <= item;
        byte_valid <= 1'b1;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        was_dropping = dec_dropping;
        got = decode_byte(item, pred);
        if (chk == CHK_RUN)
            expected_runs.push_back(typed);
        else if (chk == CHK_MODEL && got)
            expected_runs.push_back(pred);
        if (!was_dropping)
            bytes_decoded++;
        if (item.end_of_stream)
            streams_done++;
        @(negedge clk);
    endtask

    // Sends a byte sequence as one stream, the last byte ending it.
    task automatic send_seq(input logic [7:0] seq[$]);
        for (int i = 0; i < seq.size(); i++)
        begin
            send_byte('{packed_byte: seq[i], end_of_stream: (i == seq.size() - 1)},
                      CHK_MODEL, '0);
            if (!held && bytes_decoded >= 300)
            begin
                held = 1'b1;
                wait_idle();
            end
        end
    endtask

    // A well-formed stream of literals and tokens, sometimes cut short at the end.
    task automatic random_stream();
        logic [7:0] seq[$];
        seq = {};
        repeat ($urandom_range(1, 12))
        begin
            case ($urandom_range(0, 2))
                0: seq.push_back(reg_marker ^ 8'($urandom_range(1, 255)));
                1:
                begin
                    seq.push_back(reg_marker);
                    seq.push_back(TOKEN_IMPLICIT | 8'($urandom_range(0, 127)));
                end
                default:
                begin
                    seq.push_back(reg_marker);
                    seq.push_back(8'($urandom_range(0, 127)));
                    seq.push_back(8'($urandom));
                end
            endcase
        end
        case ($urandom_range(0, 7))
            0: seq.push_back(reg_marker);
            1:
            begin
                seq.push_back(reg_marker);
                seq.push_back(8'($urandom_range(0, 127)));
            end
            default: ;
        endcase
        send_seq(seq);
    endtask

    // Random bytes with a high share of markers.
    task automatic noise_stream();
        logic [7:0] seq[$];
        seq = {};
        repeat ($urandom_range(1, 20))
            seq.push_back(($urandom_range(0, 3) == 0) ? reg_marker : 8'($urandom));
        send_seq(seq);
    endtask

    // Full-length runs until the size limit is hit, then bytes that must be dropped.
    task automatic flood_stream();
        while (!dec_dropping)
        begin
            send_byte('{packed_byte: reg_marker, end_of_stream: 1'b0}, CHK_MODEL, '0);
            if ($urandom_range(0, 7) == 0)
            begin
                send_byte('{packed_byte: 8'h00, end_of_stream: 1'b0}, CHK_MODEL, '0);
                send_byte('{packed_byte: 8'($urandom), end_of_stream: 1'b0}, CHK_MODEL, '0);
            end
            else
                send_byte('{packed_byte: TOKEN_IMPLICIT, end_of_stream: 1'b0}, CHK_MODEL, '0);
        end
        repeat ($urandom_range(5, 20))
            send_byte('{packed_byte: 8'($urandom), end_of_stream: 1'b0}, CHK_MODEL, '0);
        send_byte('{packed_byte: 8'($urandom), end_of_stream: 1'b1}, CHK_MODEL, '0);
    endtask

    // Receiver stalls at random, except through the calm stretch.
    initial
    begin
        run_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            run_stall <= rst_n && !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Checks each accepted run against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && run_valid && !run_stall)
        begin
            if (expected_runs.size() == 0)
            begin
                mismatches++;
                $display("%0t: run with nothing expected, expected none, actual %p",
                         $time, run_item);
            end
            else
            begin
                next_run = expected_runs.pop_front();
                runs_checked++;
                if (run_item.limit_reached)
                    limit_runs++;
                if (run_item.run_value !== next_run.run_value)
                    report("run_value", next_run.run_value, run_item.run_value);
                if (run_item.run_length !== next_run.run_length)
                    report("run_length", next_run.run_length, run_item.run_length);
                if (run_item.limit_reached !== next_run.limit_reached)
                    report("limit_reached", next_run.limit_reached, run_item.limit_reached);
                if (run_item.last_run !== next_run.last_run)
                    report("last_run", next_run.last_run, run_item.last_run);
            end
        end
    end

    // Guards against a hang.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d runs still expected", $time, expected_runs.size());
            $display("marker_rle_run_decoder_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        byte_valid     = 1'b0;
        byte_item      = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        reg_marker     = '0;
        reg_threshold  = '0;
        reg_fill_short = '0;
        reg_fill_long  = '0;
        dec_phase      = PH_PLAIN;
        dec_pending    = '0;
        dec_total      = '0;
        dec_dropping   = 1'b0;
        cycles         = 0;
        mismatches     = 0;
        bytes_decoded  = 0;
        streams_done   = 0;
        runs_checked   = 0;
        limit_runs     = 0;
        reg_writes     = 0;
        calm           = 1'b0;
        held           = 1'b0;
        flooded        = 1'b0;

        // Directed table. Registers are all zero out of reset, so the marker is zero.
        put_byte(8'h00, 1'b0, CHK_NONE,  8'h00, 9'd0,   1'b0);
        put_byte(8'h80, 1'b0, CHK_RUN,   8'h00, 9'd256, 1'b0);
        put_byte(8'hff, 1'b0, CHK_RUN,   8'hff, 9'd1,   1'b0);
        put_byte(8'h01, 1'b1, CHK_RUN,   8'h01, 9'd1,   1'b1);
        put_reg(REG_MARKER_VALUE,     8'ha5);
        put_reg(REG_LENGTH_THRESHOLD, 8'h10);
        put_reg(REG_FIRST_FILL_BYTE,  8'h11);
        put_reg(REG_SECOND_FILL_BYTE, 8'h22);
        // Implicit runs below, at the top of, and at the threshold.
        put_byte(8'ha5, 1'b0, CHK_NONE,  8'h00, 9'd0,   1'b0);
        put_byte(8'h85, 1'b0, CHK_RUN,   8'h11, 9'd5,   1'b0);
        put_byte(8'ha5, 1'b0, CHK_NONE,  8'h00, 9'd0,   1'b0);
        put_byte(8'hff, 1'b0, CHK_RUN,   8'h22, 9'd127, 1'b0);
        put_byte(8'ha5, 1'b0, CHK_NONE,  8'h00, 9'd0,   1'b0);
        put_byte(8'h90, 1'b0, CHK_RUN,   8'h22, 9'd16,  1'b0);
        // Explicit runs: token zero means 256, then the largest short token.
        put_byte(8'ha5, 1'b0, CHK_NONE,  8'h00, 9'd0,   1'b0);
        put_byte(8'h00, 1'b0, CHK_MODEL, 8'h00, 9'd0,   1'b0);
        put_byte(8'h7e, 1'b0, CHK_RUN,   8'h7e, 9'd256, 1'b0);
        put_byte(8'ha5, 1'b0, CHK_NONE,  8'h00, 9'd0,   1'b0);
        put_byte(8'h7f, 1'b0, CHK_MODEL, 8'h00, 9'd0,   1'b0);
        put_byte(8'h33, 1'b1, CHK_RUN,   8'h33, 9'd127, 1'b1);
        // Stream ending on a token that still wants its filler, then on a bare marker.
        put_byte(8'ha5, 1'b0, CHK_NONE,  8'h00, 9'd0,   1'b0);
        put_byte(8'h03, 1'b1, CHK_RUN,   8'h00, 9'd3,   1'b1);
        put_byte(8'ha5, 1'b1, CHK_RUN,   8'h00, 9'd256, 1'b1);
        put_byte(8'h00, 1'b0, CHK_MODEL, 8'h00, 9'd0,   1'b0);
        put_byte(8'ha5, 1'b0, CHK_NONE,  8'h00, 9'd0,   1'b0);
        put_byte(8'h80, 1'b1, CHK_RUN,   8'h00, 9'd256, 1'b1);
        // Top values but a zero long fill; an index past the last register must be ignored.
        put_reg(REG_MARKER_VALUE,     8'hff);
        put_reg(REG_LENGTH_THRESHOLD, 8'hff);
        put_reg(REG_FIRST_FILL_BYTE,  8'hff);
        put_reg(REG_SECOND_FILL_BYTE, 8'h00);
        put_reg(8'hff,                8'h5a);
        put_byte(8'hff, 1'b0, CHK_NONE,  8'h00, 9'd0,   1'b0);
        put_byte(8'hfe, 1'b0, CHK_RUN,   8'hff, 9'd126, 1'b0);
        put_byte(8'h5a, 1'b1, CHK_MODEL, 8'h00, 9'd0,   1'b0);

        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
                write_reg(plan[i].a, plan[i].b);
            else
                send_byte('{packed_byte: plan[i].a, end_of_stream: plan[i].b[0]},
                          plan[i].chk, plan[i].run);
        end

        // Random phases: new register settings, then a handful of streams.
        while (bytes_decoded < BYTE_TARGET)
        begin
            for (int i = 0; i <= REG_SECOND_FILL_BYTE; i++)
            begin
                if ($urandom_range(0, 1) == 0)
                    write_reg(8'(i), ($urandom_range(0, 3) == 0)
                              ? (($urandom_range(0, 1) == 0) ? 8'h00 : 8'hff)
                              : 8'($urandom));
            end
            if ($urandom_range(0, 5) == 0)
                write_reg(8'($urandom_range(REG_SECOND_FILL_BYTE + 1, 255)), 8'($urandom));
            repeat ($urandom_range(2, 5))
            begin
                if (!flooded && bytes_decoded >= 200)
                begin
                    flooded = 1'b1;
                    flood_stream();
                end
                else if ($urandom_range(0, 99) < 80)
                    random_stream();
                else
                    noise_stream();
            end
        end

        wait_idle();
        if (expected_runs.size() != 0)
        begin
            mismatches += expected_runs.size();
            $display("%0t: %0d expected runs never arrived", $time, expected_runs.size());
        end

        $display("Decoded %0d bytes in %0d streams with %0d register writes;",
                 bytes_decoded, streams_done, reg_writes);
        $display("checked %0d runs, %0d of them at or past the size limit.",
                 runs_checked, limit_runs);
        if (mismatches == 0)
            $display("marker_rle_run_decoder_unit regression: pass");
        else
            $display("marker_rle_run_decoder_unit regression: fail");
        $finish;
    end

endmodule
